/* rtl/core/ptt_pkg.sv */
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types, codes and defaults for the periodic timer table.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int MAX_TIMERS_DEF  = 16;
  localparam int ID_POOL_DEF     = 100;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int OP_W   = 2;
  localparam int ID_W   = 7;
  localparam int IV_W   = 16;
  localparam int KIND_W = 2;
  localparam int ST_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 2'd0,
    OP_CREATE = 2'd1,
    OP_KILL   = 2'd2
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_EXPIRY = 2'd0,
    KIND_CREATE = 2'd1,
    KIND_KILL   = 2'd2
  } kind_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK           = 2'd0,
    ST_BAD_INTERVAL = 2'd1,
    ST_FULL         = 2'd2,
    ST_NOT_FOUND    = 2'd3
  } status_t;

  typedef struct packed {
    logic [OP_W-1:0] operation;
    logic [IV_W-1:0] interval;
    logic [ID_W-1:0] kill_id;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   which_timer;
    logic [ST_W-1:0]   status;
    logic              last;
  } out_item_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_TICK_RD,
    S_TICK_WR,
    S_TICK_FIN,
    S_CREATE_CHK,
    S_CREATE_SCAN,
    S_CREATE_TEST,
    S_CREATE_WR,
    S_KILL_RD,
    S_KILL_CMP,
    S_KILL_SH,
    S_KILL_MV
  } state_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_TICK,
    WR_APPEND,
    WR_MOVE
  } wr_t;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_PEND_MORE,
    EMIT_PEND_LAST,
    EMIT_CREATE,
    EMIT_KILL
  } emit_t;

  typedef struct packed {
    logic    latch;
    logic    idx_inc;
    logic    id_inc;
    logic    id_rd;
    logic    id_clr;
    logic    rd_en;
    logic    rd_next;
    wr_t     wr_mode;
    logic    live_inc;
    logic    live_dec;
    logic    busy_set;
    logic    busy_clr;
    logic    pend_load;
    emit_t   emit;
    status_t res_status;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            interval_zero;
    logic            table_full;
    logic            idx_end;
    logic            idx_last;
    logic            id_free;
    logic            id_end;
    logic            match;
    logic            expire;
    logic            pend_valid;
  } stat_t;

endpackage

/* rtl/core/ptt_ram.sv */
// ----------------------------------------------------------------------------
// ptt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/ptt_datapath.sv */
// ----------------------------------------------------------------------------
// ptt_datapath
// Timer entry store, identifier pool, walk counters and result register.
// ----------------------------------------------------------------------------
module ptt_datapath #(
  parameter int MAX_TIMERS  = ptt_pkg::MAX_TIMERS_DEF,
  parameter int ID_POOL     = ptt_pkg::ID_POOL_DEF,
  parameter int COUNT_WIDTH = ptt_pkg::COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  ptt_pkg::in_item_t  request,
  input  ptt_pkg::cmd_t      cmd,
  output ptt_pkg::stat_t     stat,
  output logic               result_strobe,
  output ptt_pkg::out_item_t result
);

  localparam int IDX_W  = $clog2(MAX_TIMERS + 1);
  localparam int ADDR_W = $clog2(MAX_TIMERS);
  localparam int IDB_W  = $clog2(ID_POOL);
  localparam int CW     = COUNT_WIDTH;
  localparam int ENT_W  = ptt_pkg::ID_W + 2 * CW;
  localparam logic [CW-1:0] CNT_MAX = '1;

  ptt_pkg::in_item_t           req;
  logic [IDX_W-1:0]            idx;
  logic [IDX_W-1:0]            idx_plus;
  logic [IDX_W-1:0]            live;
  logic [ptt_pkg::ID_W-1:0]    scan_id;
  logic [ptt_pkg::ID_W-1:0]    scan_plus;
  logic                        pend_valid;
  logic [ptt_pkg::ID_W-1:0]    pend_id;

  logic                        wr_en;
  logic [ADDR_W-1:0]           wr_addr;
  logic [ENT_W-1:0]            wr_data;
  logic [ADDR_W-1:0]           rd_addr;
  logic [ENT_W-1:0]            rd_data;

  logic                        id_wr_en;
  logic [IDB_W-1:0]            id_wr_addr;
  logic                        id_wr_data;
  logic [IDB_W-1:0]            id_rd_addr;
  logic                        id_rd_data;

  logic [ptt_pkg::ID_W-1:0]    rd_ident;
  logic [CW-1:0]               rd_count;
  logic [CW-1:0]               rd_limit;
  logic [CW-1:0]               cnt_inc;
  logic [CW-1:0]               cnt_new;
  logic                        expire;
  logic [CW-1:0]               lim;

  assign idx_plus  = idx + IDX_W'(1);
  assign scan_plus = scan_id + ptt_pkg::ID_W'(1);

  assign rd_ident = rd_data[ENT_W-1 -: ptt_pkg::ID_W];
  assign rd_count = rd_data[2*CW-1 -: CW];
  assign rd_limit = rd_data[CW-1:0];

  assign cnt_inc = (rd_count != CNT_MAX) ? rd_count + CW'(1) : rd_count;
  assign expire  = (cnt_inc >= rd_limit);
  assign cnt_new = expire ? '0 : cnt_inc;

  // saturate the requested period to the count range
  always_comb begin
    if (32'(req.interval) > 32'(CNT_MAX)) begin
      lim = CNT_MAX;
    end else begin
      lim = CW'(32'(req.interval));
    end
  end

  assign rd_addr = cmd.rd_next ? idx_plus[ADDR_W-1:0] : idx[ADDR_W-1:0];
  assign wr_en   = (cmd.wr_mode != ptt_pkg::WR_NONE);
  assign wr_addr = (cmd.wr_mode == ptt_pkg::WR_APPEND) ? live[ADDR_W-1:0] : idx[ADDR_W-1:0];

  always_comb begin
    case (cmd.wr_mode)
      ptt_pkg::WR_TICK:   wr_data = {rd_ident, cnt_new, rd_limit};
      ptt_pkg::WR_APPEND: wr_data = {scan_id, {CW{1'b0}}, lim};
      ptt_pkg::WR_MOVE:   wr_data = rd_data;
      default:            wr_data = '0;
    endcase
  end

  ptt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_TIMERS)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // identifier busy bits, cleared by a walk after reset
  assign id_wr_en   = cmd.busy_set | cmd.busy_clr | cmd.id_clr;
  assign id_wr_addr = cmd.busy_clr ? req.kill_id[IDB_W-1:0] : scan_id[IDB_W-1:0];
  assign id_wr_data = cmd.busy_set;
  assign id_rd_addr = cmd.id_inc ? scan_plus[IDB_W-1:0] : scan_id[IDB_W-1:0];

  ptt_ram #(
    .WIDTH (1),
    .DEPTH (ID_POOL)
  ) u_idents (
    .clk     (clk),
    .wr_en   (id_wr_en),
    .wr_addr (id_wr_addr),
    .wr_data (id_wr_data),
    .rd_en   (cmd.id_rd),
    .rd_addr (id_rd_addr),
    .rd_data (id_rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req <= request;
    end
    if (cmd.latch) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx_plus;
    end
    if (cmd.pend_load) begin
      pend_id <= rd_ident;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live       <= '0;
      scan_id    <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (cmd.live_inc) begin
        live <= live + IDX_W'(1);
      end else if (cmd.live_dec) begin
        live <= live - IDX_W'(1);
      end
      if (cmd.latch) begin
        scan_id <= '0;
      end else if (cmd.id_inc) begin
        scan_id <= scan_plus;
      end
      if (cmd.latch) begin
        pend_valid <= 1'b0;
      end else if (cmd.pend_load) begin
        pend_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= (cmd.emit != ptt_pkg::EMIT_NONE);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.emit)
      ptt_pkg::EMIT_PEND_MORE, ptt_pkg::EMIT_PEND_LAST: begin
        result.kind        <= ptt_pkg::KIND_EXPIRY;
        result.which_timer <= pend_id;
        result.status      <= ptt_pkg::ST_OK;
        result.last        <= (cmd.emit == ptt_pkg::EMIT_PEND_LAST);
      end
      ptt_pkg::EMIT_CREATE: begin
        result.kind        <= ptt_pkg::KIND_CREATE;
        result.which_timer <= (cmd.res_status == ptt_pkg::ST_OK) ? scan_id : '0;
        result.status      <= cmd.res_status;
        result.last        <= 1'b1;
      end
      ptt_pkg::EMIT_KILL: begin
        result.kind        <= ptt_pkg::KIND_KILL;
        result.which_timer <= req.kill_id;
        result.status      <= cmd.res_status;
        result.last        <= 1'b1;
      end
      default: begin
        result <= result;
      end
    endcase
  end

  always_comb begin
    stat.op            = req.operation;
    stat.interval_zero = (req.interval == '0);
    stat.table_full    = (live == IDX_W'(MAX_TIMERS));
    stat.idx_end       = (idx == live);
    stat.idx_last      = (idx_plus == live);
    stat.id_free       = !id_rd_data;
    stat.id_end        = (scan_id == ptt_pkg::ID_W'(ID_POOL - 1));
    stat.match         = (rd_ident == req.kill_id);
    stat.expire        = expire;
    stat.pend_valid    = pend_valid;
  end

endmodule

/* rtl/core/ptt_ctrl.sv */
// ----------------------------------------------------------------------------
// ptt_ctrl
// Sequencer for tick walks, identifier scans and kill compaction.
// ----------------------------------------------------------------------------
module ptt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  ptt_pkg::stat_t stat,
  output ptt_pkg::cmd_t  cmd,
  output logic           busy
);

  ptt_pkg::state_t state;
  ptt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptt_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ptt_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.wr_mode    = ptt_pkg::WR_NONE;
    cmd.emit       = ptt_pkg::EMIT_NONE;
    cmd.res_status = ptt_pkg::ST_OK;
    case (state)
      ptt_pkg::S_CLEAR: begin
        cmd.id_clr = 1'b1;
        cmd.id_inc = 1'b1;
        if (stat.id_end) begin
          state_next = ptt_pkg::S_IDLE;
        end
      end
      ptt_pkg::S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = ptt_pkg::S_DECODE;
        end
      end
      ptt_pkg::S_DECODE: begin
        case (stat.op)
          ptt_pkg::OP_TICK:   state_next = ptt_pkg::S_TICK_RD;
          ptt_pkg::OP_CREATE: state_next = ptt_pkg::S_CREATE_CHK;
          ptt_pkg::OP_KILL:   state_next = ptt_pkg::S_KILL_RD;
          default:            state_next = ptt_pkg::S_IDLE;
        endcase
      end
      ptt_pkg::S_TICK_RD: begin
        if (stat.idx_end) begin
          state_next = ptt_pkg::S_TICK_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = ptt_pkg::S_TICK_WR;
        end
      end
      ptt_pkg::S_TICK_WR: begin
        cmd.wr_mode = ptt_pkg::WR_TICK;
        cmd.idx_inc = 1'b1;
        // hold each expiry back one step so the final one can carry last
        if (stat.expire) begin
          cmd.pend_load = 1'b1;
          if (stat.pend_valid) begin
            cmd.emit = ptt_pkg::EMIT_PEND_MORE;
          end
        end
        state_next = ptt_pkg::S_TICK_RD;
      end
      ptt_pkg::S_TICK_FIN: begin
        if (stat.pend_valid) begin
          cmd.emit = ptt_pkg::EMIT_PEND_LAST;
        end
        state_next = ptt_pkg::S_IDLE;
      end
      ptt_pkg::S_CREATE_CHK: begin
        if (stat.interval_zero) begin
          cmd.emit       = ptt_pkg::EMIT_CREATE;
          cmd.res_status = ptt_pkg::ST_BAD_INTERVAL;
          state_next     = ptt_pkg::S_IDLE;
        end else if (stat.table_full) begin
          cmd.emit       = ptt_pkg::EMIT_CREATE;
          cmd.res_status = ptt_pkg::ST_FULL;
          state_next     = ptt_pkg::S_IDLE;
        end else begin
          state_next = ptt_pkg::S_CREATE_SCAN;
        end
      end
      ptt_pkg::S_CREATE_SCAN: begin
        cmd.id_rd  = 1'b1;
        state_next = ptt_pkg::S_CREATE_TEST;
      end
      ptt_pkg::S_CREATE_TEST: begin
        if (stat.id_free) begin
          state_next = ptt_pkg::S_CREATE_WR;
        end else if (stat.id_end) begin
          cmd.emit       = ptt_pkg::EMIT_CREATE;
          cmd.res_status = ptt_pkg::ST_FULL;
          state_next     = ptt_pkg::S_IDLE;
        end else begin
          cmd.id_rd  = 1'b1;
          cmd.id_inc = 1'b1;
        end
      end
      ptt_pkg::S_CREATE_WR: begin
        cmd.wr_mode    = ptt_pkg::WR_APPEND;
        cmd.busy_set   = 1'b1;
        cmd.live_inc   = 1'b1;
        cmd.emit       = ptt_pkg::EMIT_CREATE;
        cmd.res_status = ptt_pkg::ST_OK;
        state_next     = ptt_pkg::S_IDLE;
      end
      ptt_pkg::S_KILL_RD: begin
        if (stat.idx_end) begin
          cmd.emit       = ptt_pkg::EMIT_KILL;
          cmd.res_status = ptt_pkg::ST_NOT_FOUND;
          state_next     = ptt_pkg::S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = ptt_pkg::S_KILL_CMP;
        end
      end
      ptt_pkg::S_KILL_CMP: begin
        if (stat.match) begin
          cmd.busy_clr = 1'b1;
          state_next   = ptt_pkg::S_KILL_SH;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = ptt_pkg::S_KILL_RD;
        end
      end
      ptt_pkg::S_KILL_SH: begin
        if (stat.idx_last) begin
          cmd.live_dec   = 1'b1;
          cmd.emit       = ptt_pkg::EMIT_KILL;
          cmd.res_status = ptt_pkg::ST_OK;
          state_next     = ptt_pkg::S_IDLE;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_next = 1'b1;
          state_next  = ptt_pkg::S_KILL_MV;
        end
      end
      ptt_pkg::S_KILL_MV: begin
        cmd.wr_mode = ptt_pkg::WR_MOVE;
        cmd.idx_inc = 1'b1;
        state_next  = ptt_pkg::S_KILL_SH;
      end
      default: begin
        state_next = ptt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/periodic_timer_table.sv */
// ----------------------------------------------------------------------------
// periodic_timer_table
// Ordered table of periodic timers with create, kill and tick commands.
// ----------------------------------------------------------------------------
// tick: each live entry is read, then written back; expiry beats are issued during the walk
// create: rejects a zero interval or a full table without a scan, else scans for the lowest free identifier
// kill: compares entries up to the match, then moves each later entry down one slot
// one item at a time; the entry walk and the identifier scan set the rate
// result beats last one cycle each and cannot be stalled
// synchronous reset empties the table, then busy holds while the identifier pool is cleared
module periodic_timer_table #(
  parameter int MAX_TIMERS  = ptt_pkg::MAX_TIMERS_DEF,
  parameter int ID_POOL     = ptt_pkg::ID_POOL_DEF,
  parameter int COUNT_WIDTH = ptt_pkg::COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  ptt_pkg::in_item_t  request,
  output logic               result_strobe,
  output ptt_pkg::out_item_t result
);

  ptt_pkg::cmd_t  cmd;
  ptt_pkg::stat_t stat;

  ptt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  ptt_datapath #(
    .MAX_TIMERS  (MAX_TIMERS),
    .ID_POOL     (ID_POOL),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .request       (request),
    .cmd           (cmd),
    .stat          (stat),
    .result_strobe (result_strobe),
    .result        (result)
  );

endmodule

/* tb/periodic_timer_table_tb.sv */
// ----------------------------------------------------------------------------
// periodic_timer_table_tb
// Self-checking bench for the periodic timer table. Directed tests cover
// zero and full-range intervals, identifier reuse, kills of live, missing
// and out-of-pool identifiers, a full table and the unused operation code.
// A random mix of ticks, creates and kills follows. Every accepted command
// updates a local copy of the table, and the expected beats are queued.
// Each result beat is checked field by field against the oldest one queued.
// ----------------------------------------------------------------------------
module periodic_timer_table_tb;
  import ptt_pkg::*;

  localparam int          MAX_TIMERS   = MAX_TIMERS_DEF;
  localparam int          ID_POOL      = ID_POOL_DEF;
  localparam int unsigned COUNT_MAX    = 32'((64'd1 << COUNT_WIDTH_DEF) - 1);
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int          RANDOM_ITEMS = 300;
  localparam int          SETTLE       = 150;
  localparam int          STALL_LIMIT  = 2000;

  logic      clk = 1'b0;
  logic      rst;
  logic      start;
  logic      busy;
  in_item_t  request;
  logic      result_strobe;
  out_item_t result;

  out_item_t   awaited[$];
  out_item_t   want;
  logic [6:0]  slot_id  [MAX_TIMERS];
  int unsigned slot_cnt [MAX_TIMERS];
  int unsigned slot_lim [MAX_TIMERS];
  bit          id_taken [ID_POOL];
  int          live_count;
  int          burst_left;
  int          mismatches;
  int          stall_cycles;

  periodic_timer_table dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .request       (request),
    .result_strobe (result_strobe),
    .result        (result)
  );

  always #2 clk = ~clk;

  task automatic report_mismatch(string what);
    $display("mismatch: %s", what);
    mismatches++;
  endtask

  task automatic compare_field(string name, logic [7:0] got, logic [7:0] exp_val);
    if (got !== exp_val) begin
      report_mismatch($sformatf("%s got %0d want %0d", name, got, exp_val));
    end
  endtask

  function automatic out_item_t make_beat(kind_t k, logic [6:0] w, status_t s, logic l);
    out_item_t b;
    b.kind        = k;
    b.which_timer = w;
    b.status      = s;
    b.last        = l;
    return b;
  endfunction

  function automatic in_item_t make_cmd(logic [1:0] op, logic [15:0] iv, logic [6:0] id);
    in_item_t c;
    c.operation = op;
    c.interval  = iv;
    c.kill_id   = id;
    return c;
  endfunction

  task automatic apply_timer_command(in_item_t c);
    out_item_t   held;
    bit          have_held;
    int unsigned cnt;
    int          free_id;
    int          hit;
    have_held = 1'b0;
    case (c.operation)
      OP_TICK: begin
        for (int i = 0; i < live_count; i++) begin
          cnt = slot_cnt[i];
          if (cnt < COUNT_MAX) cnt++;
          if (cnt >= slot_lim[i]) begin
            cnt = 0;
            if (have_held) awaited.push_back(held);
            held      = make_beat(KIND_EXPIRY, slot_id[i], ST_OK, 1'b0);
            have_held = 1'b1;
          end
          slot_cnt[i] = cnt;
        end
        if (have_held) begin
          held.last = 1'b1;
          awaited.push_back(held);
        end
      end
      OP_CREATE: begin
        free_id = 0;
        while (free_id < ID_POOL && id_taken[free_id]) free_id++;
        if (c.interval == 0) begin
          awaited.push_back(make_beat(KIND_CREATE, 7'd0, ST_BAD_INTERVAL, 1'b1));
        end else if (live_count >= MAX_TIMERS || free_id >= ID_POOL) begin
          awaited.push_back(make_beat(KIND_CREATE, 7'd0, ST_FULL, 1'b1));
        end else begin
          id_taken[free_id]    = 1'b1;
          slot_id[live_count]  = free_id[6:0];
          slot_cnt[live_count] = 0;
          slot_lim[live_count] = (32'(c.interval) > COUNT_MAX) ? COUNT_MAX : 32'(c.interval);
          live_count++;
          awaited.push_back(make_beat(KIND_CREATE, free_id[6:0], ST_OK, 1'b1));
        end
      end
      OP_KILL: begin
        hit = -1;
        for (int i = 0; i < live_count && hit < 0; i++) begin
          if (slot_id[i] == c.kill_id) hit = i;
        end
        if (hit < 0) begin
          awaited.push_back(make_beat(KIND_KILL, c.kill_id, ST_NOT_FOUND, 1'b1));
        end else begin
          if (slot_id[hit] < ID_POOL) id_taken[slot_id[hit]] = 1'b0;
          for (int j = hit; j + 1 < live_count; j++) begin
            slot_id[j]  = slot_id[j+1];
            slot_cnt[j] = slot_cnt[j+1];
            slot_lim[j] = slot_lim[j+1];
          end
          live_count--;
          awaited.push_back(make_beat(KIND_KILL, c.kill_id, ST_OK, 1'b1));
        end
      end
      default: begin
      end
    endcase
  endtask

  // drives one command beat, idling between bursts
  task automatic send_beat(in_item_t c);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
    request <= c;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_timer_command(c);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (awaited.size() != 0) @(posedge clk);
  endtask

  task automatic test_create_answers();
    send_beat(make_cmd(OP_CREATE, 16'd0, 7'($urandom)));
    send_beat(make_cmd(OP_CREATE, 16'd1, 7'd127));
    send_beat(make_cmd(OP_CREATE, 16'hFFFF, 7'd0));
    send_beat(make_cmd(OP_CREATE, 16'd2, 7'($urandom)));
  endtask

  task automatic test_tick_expiry();
    send_beat(make_cmd(OP_TICK, 16'($urandom), 7'($urandom)));
    send_beat(make_cmd(OP_TICK, 16'($urandom), 7'($urandom)));
  endtask

  task automatic test_unused_code();
    send_beat(make_cmd(OP_UNUSED, 16'($urandom), 7'($urandom)));
  endtask

  task automatic test_kill_answers();
    send_beat(make_cmd(OP_KILL, 16'($urandom), 7'd1));
    send_beat(make_cmd(OP_KILL, 16'($urandom), 7'd1));
    send_beat(make_cmd(OP_KILL, 16'hFFFF, 7'd127));
    send_beat(make_cmd(OP_KILL, 16'd0, 7'(ID_POOL)));
    // freed identifier is the lowest free one again
    send_beat(make_cmd(OP_CREATE, 16'd1, 7'($urandom)));
  endtask

  task automatic test_table_full();
    while (live_count < MAX_TIMERS) send_beat(make_cmd(OP_CREATE, 16'd1, 7'($urandom)));
    send_beat(make_cmd(OP_CREATE, 16'd3, 7'($urandom)));
    send_beat(make_cmd(OP_TICK, 16'($urandom), 7'($urandom)));
    send_beat(make_cmd(OP_KILL, 16'($urandom), 7'd0));
  endtask

  task automatic test_random_mix();
    int          r;
    logic [15:0] iv;
    logic [6:0]  id;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) wait_drained();
      r  = $urandom_range(0, 99);
      iv = 16'($urandom);
      id = 7'($urandom);
      if (r < 5) begin
        send_beat(make_cmd(OP_UNUSED, iv, id));
      end else if (r < 45) begin
        send_beat(make_cmd(OP_TICK, iv, id));
      end else if (r < 72) begin
        case ($urandom_range(0, 19))
          0:       iv = 16'd0;
          1:       iv = 16'($urandom);
          2:       iv = 16'hFFFF;
          default: iv = 16'($urandom_range(1, 6));
        endcase
        send_beat(make_cmd(OP_CREATE, iv, id));
      end else begin
        if (live_count > 0 && $urandom_range(0, 4) != 0) begin
          id = slot_id[$urandom_range(0, live_count - 1)];
        end
        send_beat(make_cmd(OP_KILL, iv, id));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_strobe) begin
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("beat with nothing awaited: kind %0d timer %0d status %0d",
                                  result.kind, result.which_timer, result.status));
      end else begin
        want = awaited.pop_front();
        compare_field("kind", 8'(result.kind), 8'(want.kind));
        compare_field("which_timer", 8'(result.which_timer), 8'(want.which_timer));
        compare_field("status", 8'(result.status), 8'(want.status));
        compare_field("last", 8'(result.last), 8'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    request      = '0;
    live_count   = 0;
    burst_left   = 0;
    mismatches   = 0;
    for (int k = 0; k < ID_POOL; k++) id_taken[k] = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_create_answers();
    test_tick_expiry();
    test_unused_code();
    test_kill_answers();
    test_table_full();
    wait_drained();
    test_random_mix();
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (awaited.size() != 0) begin
      report_mismatch($sformatf("%0d result beats never arrived", awaited.size()));
    end
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/ptt_pkg.sv
rtl/core/ptt_ram.sv
rtl/core/ptt_datapath.sv
rtl/core/ptt_ctrl.sv
rtl/core/periodic_timer_table.sv
tb/periodic_timer_table_tb.sv
